@@ design/mbe_pkg.sv @@
// ============================================================================
// mbe_pkg
// Shared types, constants and register codes for the Mandelbrot escape-time
// pixel evaluator.
// ============================================================================
package mbe_pkg;

    // Field and datapath widths
    localparam int FRAC_BITS_DEFAULT = 27;
    localparam int COUNT_BITS        = 10;
    localparam int WORD_W            = 32;
    localparam int STEP_W            = 27;
    localparam int PIX_W             = 10;
    localparam int COLOR_W           = 3;
    localparam int PROD_W            = 2 * WORD_W;
    localparam int ADDR_W            = 4;
    localparam int DATA_W            = 32;

    // Register reset values (coordinates in Q5.27)
    localparam logic signed [WORD_W-1:0] CORNER_REAL_RST = -32'sd268435456;
    localparam logic signed [WORD_W-1:0] CORNER_IMAG_RST = -32'sd201326592;
    localparam logic [STEP_W-1:0]        PIXEL_STEP_RST  = 27'd393216;
    localparam logic [COUNT_BITS-1:0]    MAX_ITER_RST    = 10'd100;

    // Register index, taken from paddr word address
    typedef enum logic [1:0] {
        REG_CORNER_REAL = 2'd0,
        REG_CORNER_IMAG = 2'd1,
        REG_PIXEL_STEP  = 2'd2,
        REG_MAX_ITER    = 2'd3
    } reg_idx_t;

    // Output color codes
    typedef enum logic [COLOR_W-1:0] {
        COLOR_YELLOW = 3'd0,
        COLOR_BLUE   = 3'd1,
        COLOR_GREEN  = 3'd2,
        COLOR_RED    = 3'd3,
        COLOR_BLACK  = 3'd4
    } color_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_ADD,
        ST_ITER_MUL,
        ST_ITER_CHECK,
        ST_FINISH
    } state_t;

    // Configuration register set
    typedef struct packed {
        logic signed [WORD_W-1:0] corner_real;
        logic signed [WORD_W-1:0] corner_imag;
        logic [STEP_W-1:0]        pixel_step;
        logic [COUNT_BITS-1:0]    max_iterations;
    } cfg_t;

    // Multiplier unit request: three operand pairs and a load strobe
    typedef struct packed {
        logic                     en;
        logic signed [WORD_W-1:0] a0;
        logic signed [WORD_W-1:0] b0;
        logic signed [WORD_W-1:0] a1;
        logic signed [WORD_W-1:0] b1;
        logic signed [WORD_W-1:0] a2;
        logic signed [WORD_W-1:0] b2;
    } mul_req_t;

    // Multiplier unit registered products
    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
    } mul_res_t;

endpackage

@@ design/mbe_ifs.sv @@
// ============================================================================
// mbe_ifs
// Valid/ready channel interfaces for pixel coordinates and pixel results.
// ============================================================================
interface mbe_pix_in_if import mbe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] column;
    logic [PIX_W-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbe_pix_out_if import mbe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] iterations;
    logic [COLOR_W-1:0]    color_code;

    modport source (output valid, output iterations, output color_code, input ready);
    modport sink   (input valid, input iterations, input color_code, output ready);
endinterface

@@ design/mbe_cfg_regs.sv @@
// ============================================================================
// mbe_cfg_regs
// APB-style configuration registers: image corner, pixel step and iteration
// limit. Writes complete in the access phase; reads return register values.
// ============================================================================
module mbe_cfg_regs import mbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    // Decode word address and write strobe
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.corner_real    <= CORNER_REAL_RST;
            cfg_reg.corner_imag    <= CORNER_IMAG_RST;
            cfg_reg.pixel_step     <= PIXEL_STEP_RST;
            cfg_reg.max_iterations <= MAX_ITER_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CORNER_REAL: cfg_reg.corner_real    <= $signed(pwdata[WORD_W-1:0]);
                REG_CORNER_IMAG: cfg_reg.corner_imag    <= $signed(pwdata[WORD_W-1:0]);
                REG_PIXEL_STEP:  cfg_reg.pixel_step     <= pwdata[STEP_W-1:0];
                REG_MAX_ITER:    cfg_reg.max_iterations <= pwdata[COUNT_BITS-1:0];
                default:         cfg_reg.max_iterations <= cfg_reg.max_iterations;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (idx)
            REG_CORNER_REAL: prdata = DATA_W'($unsigned(cfg_reg.corner_real));
            REG_CORNER_IMAG: prdata = DATA_W'($unsigned(cfg_reg.corner_imag));
            REG_PIXEL_STEP:  prdata = DATA_W'(cfg_reg.pixel_step);
            REG_MAX_ITER:    prdata = DATA_W'(cfg_reg.max_iterations);
            default:         prdata = '0;
        endcase
    end

endmodule

@@ design/mbe_mul_unit.sv @@
// ============================================================================
// mbe_mul_unit
// Shared multiplier unit: three signed 32x32 products, registered. Used for
// the pixel-to-coordinate scaling and for every z^2 step.
// ============================================================================
module mbe_mul_unit import mbe_pkg::*;
(
    input  logic     clk,
    input  mul_req_t req,
    output mul_res_t res
);

    mul_res_t res_reg;

    assign res = res_reg;

    // Load full-width products when strobed
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            res_reg.p0 <= PROD_W'(req.a0) * PROD_W'(req.b0);
            res_reg.p1 <= PROD_W'(req.a1) * PROD_W'(req.b1);
            res_reg.p2 <= PROD_W'(req.a2) * PROD_W'(req.b2);
        end
    end

endmodule

@@ design/mbe_engine.sv @@
// ============================================================================
// mbe_engine
// Escape-time sequencer: forms c from the pixel index, iterates z = z^2 + c
// on the shared multiplier unit, classifies the count and holds the result.
// ============================================================================
module mbe_engine import mbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    mbe_pix_in_if.sink           pix_in,
    mbe_pix_out_if.source        pix_out,
    output mul_req_t             mul_req,
    input  mul_res_t             mul_res
);

    // Accumulator wide enough for a product plus a shifted c term
    localparam int ACC_W = (FRAC_BITS + 34 > 65) ? FRAC_BITS + 34 : 65;
    // Escape threshold 4 in the squared scale; unreachable if it does not fit
    localparam bit              NO_ESCAPE = (2 * FRAC_BITS + 2) >= PROD_W;
    localparam logic [PROD_W-1:0] FOUR    = NO_ESCAPE ? '0
                                          : (PROD_W'(1) << (2 * FRAC_BITS + 2));

    state_t                    state_reg, state_next;
    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic signed [WORD_W-1:0]  zx_reg, zx_next;
    logic signed [WORD_W-1:0]  zy_reg, zy_next;
    logic signed [WORD_W-1:0]  ca_reg, ca_next;
    logic signed [WORD_W-1:0]  cb_reg, cb_next;
    logic                      out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0]     out_iter_reg, out_iter_next;
    color_t                    out_color_reg, out_color_next;

    logic                      in_acc;
    logic                      out_free;
    logic [PROD_W-1:0]         mag;
    logic                      escape;
    logic signed [ACC_W-1:0]   acc_x;
    logic signed [ACC_W-1:0]   acc_y;
    logic signed [ACC_W-1:0]   acc_ca;
    logic signed [ACC_W-1:0]   acc_cb;
    logic signed [WORD_W-1:0]  zx_new;
    logic signed [WORD_W-1:0]  zy_new;
    logic signed [WORD_W-1:0]  ca_new;
    logic signed [WORD_W-1:0]  cb_new;
    logic [COUNT_BITS+1:0]     lim_x3;
    logic [COUNT_BITS-1:0]     band1;
    logic [COUNT_BITS-1:0]     band2;
    logic [COUNT_BITS-1:0]     band3;
    color_t                    color_new;

    // Clamp an accumulator value to the signed 32-bit range
    function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-WORD_W:0] hi;
        hi = v[ACC_W-1:WORD_W-1];
        if ((&hi) || !(|hi))
            return v[WORD_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(WORD_W-1){1'b0}}};
        else
            return {1'b0, {(WORD_W-1){1'b1}}};
    endfunction

    // Handshake
    assign pix_in.ready       = (state_reg == ST_IDLE);
    assign in_acc             = pix_in.valid && pix_in.ready;
    assign out_free           = !out_valid_reg || pix_out.ready;
    assign pix_out.valid      = out_valid_reg;
    assign pix_out.iterations = out_iter_reg;
    assign pix_out.color_code = out_color_reg;

    // c = corner + index * step, saturated
    assign acc_ca = ACC_W'(mul_res.p0) + ACC_W'($signed(cfg.corner_real));
    assign acc_cb = ACC_W'(mul_res.p1) + ACC_W'($signed(cfg.corner_imag));
    assign ca_new = sat_acc(acc_ca);
    assign cb_new = sat_acc(acc_cb);

    // Magnitude test and next z; c is folded in before the floor shift
    assign mag    = $unsigned(mul_res.p0) + $unsigned(mul_res.p1);
    assign escape = !NO_ESCAPE && (mag > FOUR);
    assign acc_x  = ACC_W'(mul_res.p0) - ACC_W'(mul_res.p1)
                  + (ACC_W'(ca_reg) <<< FRAC_BITS);
    assign acc_y  = ACC_W'(mul_res.p2) + (ACC_W'(cb_reg) <<< (FRAC_BITS - 1));
    assign zx_new = sat_acc(acc_x >>> FRAC_BITS);
    assign zy_new = sat_acc(acc_y >>> (FRAC_BITS - 1));

    // Quarter-band thresholds of the limit
    assign lim_x3 = (COUNT_BITS+2)'(cfg.max_iterations)
                  + {1'b0, cfg.max_iterations, 1'b0};
    assign band1  = cfg.max_iterations >> 2;
    assign band2  = cfg.max_iterations >> 1;
    assign band3  = lim_x3[COUNT_BITS+1:2];

    // Pick the color band for the finished count
    always_comb
    begin
        if (count_reg == cfg.max_iterations)
            color_new = COLOR_BLACK;
        else if (count_reg >= band3)
            color_new = COLOR_RED;
        else if (count_reg >= band2)
            color_new = COLOR_GREEN;
        else if (count_reg >= band1)
            color_new = COLOR_BLUE;
        else
            color_new = COLOR_YELLOW;
    end

    // Sequencer: next state, multiplier operands, datapath updates
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        zx_next        = zx_reg;
        zy_next        = zy_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        out_valid_next = out_valid_reg && !pix_out.ready;
        out_iter_next  = out_iter_reg;
        out_color_next = out_color_reg;

        mul_req.en = 1'b0;
        mul_req.a0 = zx_reg;
        mul_req.b0 = zx_reg;
        mul_req.a1 = zy_reg;
        mul_req.b1 = zy_reg;
        mul_req.a2 = zx_reg;
        mul_req.b2 = zy_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // Scale column and row by the pixel step
                mul_req.a0 = WORD_W'(pix_in.column);
                mul_req.b0 = WORD_W'(cfg.pixel_step);
                mul_req.a1 = WORD_W'(pix_in.row);
                mul_req.b1 = WORD_W'(cfg.pixel_step);
                mul_req.a2 = '0;
                mul_req.b2 = '0;
                if (in_acc)
                begin
                    mul_req.en = 1'b1;
                    state_next = ST_SETUP_ADD;
                end
            end
            ST_SETUP_ADD:
            begin
                ca_next    = ca_new;
                cb_next    = cb_new;
                zx_next    = '0;
                zy_next    = '0;
                count_next = '0;
                state_next = ST_ITER_MUL;
            end
            ST_ITER_MUL:
            begin
                if (count_reg >= cfg.max_iterations)
                    state_next = ST_FINISH;
                else
                begin
                    mul_req.en = 1'b1;
                    state_next = ST_ITER_CHECK;
                end
            end
            ST_ITER_CHECK:
            begin
                if (escape)
                    state_next = ST_FINISH;
                else
                begin
                    zx_next    = zx_new;
                    zy_next    = zy_new;
                    count_next = count_reg + 1'b1;
                    state_next = ST_ITER_MUL;
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_iter_next  = count_reg;
                    out_color_next = color_new;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        zx_reg        <= zx_next;
        zy_reg        <= zy_next;
        ca_reg        <= ca_next;
        cb_reg        <= cb_next;
        out_iter_reg  <= out_iter_next;
        out_color_reg <= out_color_next;
    end

endmodule

@@ design/mandelbrot_escape_time_pixel_top.sv @@
// ============================================================================
// mandelbrot_escape_time_pixel_top
// Mandelbrot escape-time evaluator for one pixel per transaction, with an
// APB-style register port for image corner, pixel step and iteration limit.
// ============================================================================
//
//   Channel   Direction  Handshake        Payload
//   pix_in    in         valid / ready    column[9:0], row[9:0]
//   pix_out   out        valid / ready    iterations[9:0], color_code[2:0]
//   apb       in         psel / penable   paddr[3:0], pwdata / prdata[31:0]
//
// Each iteration is one pass through the shared multiplier unit followed by
// one add-and-test step.
// pix_in is ready only while the sequencer is idle. One finished result
// waits in the output register, so a new pixel is taken while pix_out
// stalls; a pixel finishing under a stall holds until that register empties.
// Reset restores the register defaults and empties the output register.
//
module mandelbrot_escape_time_pixel_top import mbe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    mbe_pix_in_if.sink        pix_in,
    mbe_pix_out_if.source     pix_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg;
    mul_req_t mul_req;
    mul_res_t mul_res;

    // Configuration registers
    mbe_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared multiplier unit
    mbe_mul_unit u_mul_unit (
        .clk (clk),
        .req (mul_req),
        .res (mul_res)
    );

    // Iteration sequencer
    mbe_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pix_in  (pix_in),
        .pix_out (pix_out),
        .mul_req (mul_req),
        .mul_res (mul_res)
    );

endmodule

@@ design/mbe_checker.sv @@
// ============================================================================
// mbe_checker
// Port-level checks on the pixel channels of the escape-time evaluator.
// ============================================================================
module mbe_checker import mbe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COUNT_BITS-1:0] out_iterations,
    input logic [COLOR_W-1:0]    out_color
);

    // Hold a stalled result until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pix_out valid dropped while stalled");

    // Keep stalled result payload steady
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_iterations) && $stable(out_color))
        else $error("pix_out payload changed while stalled");

    // Drop ready once a pixel is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("pix_in ready held after a transaction");

    // Never produce a result the cycle after a pixel is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("pix_out result appeared one cycle after pix_in transaction");

endmodule

bind mandelbrot_escape_time_pixel_top mbe_checker u_mbe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pix_in.valid),
    .in_ready       (pix_in.ready),
    .out_valid      (pix_out.valid),
    .out_ready      (pix_out.ready),
    .out_iterations (pix_out.iterations),
    .out_color      (pix_out.color_code)
);

@@ bench/tb.sv @@
// ============================================================================
// tb
// Self-checking bench for the Mandelbrot escape-time pixel evaluator. Pixels
// are pushed through the valid/ready input channel with random gaps. Results
// are drained with random stalls and compared against a fixed-point
// predictor. The view registers are reprogrammed over APB between phases:
// directed corners, saturation and zero-limit cases first, then random views.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    localparam int   FRAC          = FRAC_BITS_DEFAULT;
    localparam int   RANDOM_PIXELS = 1050;
    localparam int   CYCLE_LIMIT   = 10_000_000;
    localparam int   MAX_GAP       = 18;
    localparam int   REPORT_MAX    = 10;
    localparam int   SETTLE_CYCLES = 40;
    localparam longint WORD_HI     = 64'sd2147483647;
    localparam longint WORD_LO     = -64'sd2147483648;
    // |z|^2 bound of 4 in the squared (2*FRAC) scale
    localparam logic [63:0] RADIUS_SQ = 64'd4 << (2 * FRAC);

    typedef struct {
        logic [COUNT_BITS-1:0] iterations;
        color_t                color;
    } escape_t;

    // ------------------------------------------------------------------------
    // Predictor and result checker
    // ------------------------------------------------------------------------
    class escape_scoreboard;
        logic signed [WORD_W-1:0] corner_real;
        logic signed [WORD_W-1:0] corner_imag;
        logic [STEP_W-1:0]        pixel_step;
        logic [COUNT_BITS-1:0]    max_iterations;
        escape_t                  escapes_due[$];
        int                       checked;
        int                       failures;
        int                       by_color[5];

        function new();
            corner_real    = CORNER_REAL_RST;
            corner_imag    = CORNER_IMAG_RST;
            pixel_step     = PIXEL_STEP_RST;
            max_iterations = MAX_ITER_RST;
            checked        = 0;
            failures       = 0;
            by_color       = '{default: 0};
        endfunction

        function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_CORNER_REAL: corner_real    = value;
                REG_CORNER_IMAG: corner_imag    = value;
                REG_PIXEL_STEP:  pixel_step     = value[STEP_W-1:0];
                REG_MAX_ITER:    max_iterations = value[COUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_word(longint v);
            if (v > WORD_HI)
                return WORD_HI;
            if (v < WORD_LO)
                return WORD_LO;
            return v;
        endfunction

        // Run the escape iteration for an accepted pixel and queue its result
        function void note_pixel(logic [PIX_W-1:0] column, logic [PIX_W-1:0] row);
            longint      ca;
            longint      cb;
            longint      zx;
            longint      zy;
            longint      xx;
            longint      yy;
            longint      nx;
            logic [63:0] mag;
            int          n;
            int          m;
            escape_t     e;
            ca = clamp_word(longint'(corner_real) + longint'(column) * longint'(pixel_step));
            cb = clamp_word(longint'(corner_imag) + longint'(row) * longint'(pixel_step));
            zx = 0;
            zy = 0;
            n  = 0;
            m  = int'(max_iterations);
            while (n < m)
            begin
                xx  = zx * zx;
                yy  = zy * zy;
                mag = xx + yy;
                if (mag > RADIUS_SQ)
                    break;
                n++;
                // 2*zx*zy folds into a shift one bit short of FRAC
                nx = clamp_word(((xx - yy) >>> FRAC) + ca);
                zy = clamp_word(((zx * zy) >>> (FRAC - 1)) + cb);
                zx = nx;
            end
            if (n == m)
                e.color = COLOR_BLACK;
            else if (n >= (3 * m) / 4)
                e.color = COLOR_RED;
            else if (n >= (2 * m) / 4)
                e.color = COLOR_GREEN;
            else if (n >= m / 4)
                e.color = COLOR_BLUE;
            else
                e.color = COLOR_YELLOW;
            e.iterations = n[COUNT_BITS-1:0];
            escapes_due.push_back(e);
        endfunction

        // Compare one delivered result with the oldest outstanding pixel
        function void check_pixel_result(logic [COUNT_BITS-1:0] iterations,
                                         logic [COLOR_W-1:0] color_code);
            escape_t e;
            checked++;
            if (escapes_due.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("[%0t] result with no pixel outstanding: iterations %0d color %0d",
                             $time, iterations, color_code);
                return;
            end
            e = escapes_due.pop_front();
            by_color[int'(e.color)]++;
            if (iterations !== e.iterations || color_code !== e.color)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("[%0t] result %0d: iterations %0d expected %0d, %s",
                             $time, checked, iterations, e.iterations,
                             $sformatf("color %0d expected %0d (%s)",
                                       color_code, e.color, e.color.name()));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, channels and the block
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit                in_calm;
    bit                out_calm;
    int                cycles;
    int                settings;
    int                pixels_sent;
    int                directed_sent;

    escape_scoreboard  escape_check = new();

    mbe_pix_in_if  pixels();
    mbe_pix_out_if escapes();

    mandelbrot_escape_time_pixel_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pixels),
        .pix_out (escapes),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, escape_check.escapes_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one pixel after a random gap and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] column, input logic [PIX_W-1:0] row);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            pixels.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixels.valid  <= 1'b1;
        pixels.column <= column;
        pixels.row    <= row;
        do @(posedge clk); while (!(pixels.valid && pixels.ready === 1'b1));
        escape_check.note_pixel(column, row);
        pixels_sent++;
    endtask

    // Run one APB write; psel stays high so writes can go back to back
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        escape_check.set_reg(idx, value);
    endtask

    // Load a whole view: corner, step and limit
    task automatic program_view(input logic [DATA_W-1:0] corner_re,
                                input logic [DATA_W-1:0] corner_im,
                                input logic [DATA_W-1:0] step,
                                input logic [DATA_W-1:0] limit);
        write_reg(REG_CORNER_REAL, corner_re);
        write_reg(REG_CORNER_IMAG, corner_im);
        write_reg(REG_PIXEL_STEP, step);
        write_reg(REG_MAX_ITER, limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings++;
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        pixels.valid <= 1'b0;
        while (escape_check.escapes_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls between transactions
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        escapes.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                escapes.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            escapes.ready <= 1'b1;
            do @(posedge clk); while (!(escapes.valid === 1'b1 && escapes.ready));
            escape_check.check_pixel_result(escapes.iterations, escapes.color_code);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int random_sent;
        int kind;
        int count;
        int cr;
        int ci;
        int step;
        int limit;

        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pixels.valid  = 1'b0;
        pixels.column = '0;
        pixels.row    = '0;
        random_sent   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset view: image corners, interior points, c = -2 on the |z|^2 = 4 boundary
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd512);
        send_pixel(10'd341, 10'd512);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);
        drain();

        // Extreme corners and widest step: c saturates on both parts
        program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h07FF_FFFF, 32'd1023);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        drain();

        // Zero limit: no iteration, black
        program_view(CORNER_REAL_RST, CORNER_IMAG_RST, DATA_W'(PIXEL_STEP_RST), 32'd0);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();

        // Limit of one with a zero step
        program_view(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
        send_pixel(10'd1023, 10'd1023);
        drain();

        // Deepest limit on points that never escape
        program_view(CORNER_REAL_RST, CORNER_IMAG_RST, DATA_W'(PIXEL_STEP_RST), 32'd1023);
        send_pixel(10'd683, 10'd512);
        send_pixel(10'd0, 10'd512);
        send_pixel(10'd341, 10'd512);
        drain();
        directed_sent = pixels_sent;

        // Random views, mostly around the set with short limits
        while (random_sent < RANDOM_PIXELS)
        begin
            kind     = $urandom_range(0, 9);
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if (kind == 0)
            begin
                // any register value; c is mostly far outside
                program_view($urandom(), $urandom(), $urandom_range(0, 27'h7FF_FFFF),
                             $urandom_range(0, 1023));
                count = $urandom_range(20, 60);
            end
            else if (kind == 1)
            begin
                // long limits are slow: keep the pixel count low
                program_view(CORNER_REAL_RST, CORNER_IMAG_RST, DATA_W'(PIXEL_STEP_RST),
                             $urandom_range(256, 1023));
                count = $urandom_range(3, 6);
            end
            else
            begin
                cr    = -335544320 + int'($urandom_range(0, 268435456));
                ci    = -268435456 + int'($urandom_range(0, 201326592));
                step  = $urandom_range(1, 786432);
                limit = $urandom_range(1, 64);
                program_view(cr, ci, step, limit);
                count = $urandom_range(30, 70);
            end
            repeat (count)
            begin
                send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
                random_sent++;
            end
            drain();
        end

        // Let any stray result surface before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Evaluated %0d pixels (%0d directed) over %0d register views",
                 pixels_sent, directed_sent, settings);
        $display("%0d results checked; expected bands: yellow %0d, blue %0d, %s",
                 escape_check.checked, escape_check.by_color[0], escape_check.by_color[1],
                 $sformatf("green %0d, red %0d, black %0d",
                           escape_check.by_color[2], escape_check.by_color[3],
                           escape_check.by_color[4]));
        if (escape_check.failures == 0 && escape_check.escapes_due.size() == 0)
            $display("SUCCESS");
        else
        begin
            $display("%0d mismatches, %0d results missing",
                     escape_check.failures, escape_check.escapes_due.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
